>>> rtl/modular_exponentiation_32_assert.svh
// assertion macros for the modular exponentiation block
// no dependencies; included by modules that carry concurrent checks
`ifndef MODULAR_EXPONENTIATION_32_ASSERT_SVH
`define MODULAR_EXPONENTIATION_32_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MEXP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mexp assertion failed");
// expression must never be true outside reset
`define MEXP_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("mexp forbidden condition");
`else
`define MEXP_ASSERT(lbl, clk, rstn, prop)
`define MEXP_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/mexp_pkg.sv
// types and constants for the modular exponentiation block
// no dependencies; imported by modular_exponentiation_32
package mexp_pkg;

    localparam int DATA_BITS = 32;

    // func field codes
    localparam logic FUNC_MOD  = 1'b0;
    localparam logic FUNC_WRAP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_NEXT,
        ST_FIN
    } state_t;

    // which operation the shared multiply-reduce unit is running
    typedef enum logic [1:0] {
        OP_BASE,
        OP_ACC,
        OP_SQR
    } op_t;

    typedef struct packed {
        logic                 func;
        logic [DATA_BITS-1:0] base;
        logic [DATA_BITS-1:0] exponent;
        logic [DATA_BITS-1:0] modulus;
    } mexp_req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] power;
        logic                 bad_modulus;
    } mexp_rsp_t;

endpackage

>>> rtl/modular_exponentiation_32.sv
// modular exponentiation by right-to-left square-and-multiply
// depends on mexp_pkg and modular_exponentiation_32_assert.svh
//
// channel  dir  handshake             beat
// req      in   req_valid/req_stall   func, base, exponent, modulus
// rsp      out  rsp_valid/rsp_stall   power, bad_modulus
//
// one shared multiply-reduce unit: a WORD_BITS x WORD_BITS multiply into the
// product register, then WORD_BITS restoring shift-subtract steps by the modulus
// mode 0: one base reduction, one operation per set exponent bit, and one
// square per exponent bit below the top set bit
// mode 1: the low half of each product is taken, no reduction steps
// zero modulus in mode 0 goes straight to a bad_modulus result; reset needs no clearing pass
// a new request is taken while a result waits under rsp_stall; a finished
// result then waits in the sequencer until the output register frees up
`include "modular_exponentiation_32_assert.svh"

module modular_exponentiation_32 #(
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mexp_pkg::mexp_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mexp_pkg::mexp_rsp_t rsp_data
);
    import mexp_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    // sequencer and control
    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // operands and working values
    logic            func_reg, func_next;
    logic            bad_reg, bad_next;
    logic [W-1:0]    mod_reg, mod_next;
    logic [W-1:0]    exp_reg, exp_next;
    logic [W-1:0]    base_reg, base_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [2*W-1:0]  prod_reg, prod_next;
    mexp_rsp_t       rsp_reg, rsp_next;

    // shared unit signals
    logic [W-1:0]    mul_x, mul_y;
    logic [2*W-1:0]  mul_prod;
    logic [W-1:0]    prod_hi;
    logic [W:0]      trial, diff;
    logic            fits;
    logic [W-1:0]    rem;
    logic [W-1:0]    red_result;
    logic            red_done;

    // sequencing helpers
    logic            req_fire;
    logic            rsp_free;
    logic            take_acc;
    logic [W-1:0]    exp_shift;
    logic            last_bit;
    logic [W-1:0]    req_mod;

    assign req_fire = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign req_mod  = req_data.modulus[W-1:0];

    // multiplier: acc*base, base*base, or base*1 to reduce the raw base
    assign mul_x    = (op_reg == OP_ACC) ? acc_reg : base_reg;
    assign mul_y    = (op_reg == OP_BASE) ? W'(1) : base_reg;
    assign mul_prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

    // one restoring step: shift the next product bit into the remainder
    assign prod_hi  = prod_reg[2*W-1:W];
    assign trial    = {prod_hi, prod_reg[W-1]};
    assign diff     = trial - {1'b0, mod_reg};
    assign fits     = trial >= {1'b0, mod_reg};
    assign rem      = fits ? diff[W-1:0] : trial[W-1:0];

    // wrap mode takes the low half straight away
    assign red_result = (func_reg == FUNC_WRAP) ? prod_reg[W-1:0] : rem;
    assign red_done   = (func_reg == FUNC_WRAP) || (cnt_reg == LAST_STEP);

    // multiply acc in once per set bit, then square unless no bits remain
    assign take_acc  = (op_reg != OP_ACC) && exp_reg[0];
    assign exp_shift = exp_reg >> 1;
    assign last_bit  = (exp_shift == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_data.func == FUNC_WRAP)
                        state_next = ST_NEXT;
                    else if (req_mod == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_RED;
            ST_RED:
            begin
                if (red_done)
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (take_acc)
                    state_next = ST_MUL;
                else if (last_bit)
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_FIN:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        bad_next       = bad_reg;
        mod_next       = mod_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    func_next = req_data.func;
                    mod_next  = req_mod;
                    exp_next  = req_data.exponent[W-1:0];
                    base_next = req_data.base[W-1:0];
                    acc_next  = W'(1);
                    op_next   = OP_BASE;
                    bad_next  = (req_data.func == FUNC_MOD) && (req_mod == '0);
                end
            end
            ST_MUL:
            begin
                prod_next = mul_prod;
                cnt_next  = '0;
            end
            ST_RED:
            begin
                prod_next = {rem, prod_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg + CW'(1);
                if (red_done)
                begin
                    if (op_reg == OP_ACC)
                        acc_next = red_result;
                    else
                        base_next = red_result;
                end
            end
            ST_NEXT:
            begin
                if (take_acc)
                    op_next = OP_ACC;
                else if (!last_bit)
                begin
                    exp_next = exp_shift;
                    op_next  = OP_SQR;
                end
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.power       = bad_reg ? '0 : DATA_BITS'(acc_reg);
                    rsp_next.bad_modulus = bad_reg;
                end
            end
            default:
            begin
                op_next = OP_BASE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_BASE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        bad_reg  <= bad_next;
        mod_reg  <= mod_next;
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // a taken request keeps the block busy on the next cycle
    `MEXP_ASSERT(a_busy_after_req, clk, rst_n, req_fire |=> req_stall)
    // operands below the modulus keep the running remainder below it
    `MEXP_ASSERT(a_rem_below_mod, clk, rst_n,
        (state_reg == ST_RED && func_reg == FUNC_MOD) |-> (prod_hi < mod_reg))
    // an error beat always carries a zero power
    `MEXP_ASSERT(a_bad_zero_power, clk, rst_n,
        (rsp_valid && rsp_data.bad_modulus) |-> (rsp_data.power == '0))
    // a finished result is never dropped onto a stalled output
    `MEXP_NEVER(a_no_overwrite, clk, rst_n,
        (state_reg == ST_FIN) && rsp_valid_reg && rsp_stall && (state_next == ST_IDLE))

endmodule
